// ===== sv/ubdc_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and the divider step for the UART baud divisor calculator.
// Depends on nothing; used by uart_baud_divisor_calc_core.
package ubdc_pkg;

    localparam int CLK_W    = 28;
    localparam int BAUD_W   = 24;
    localparam int WORD_W   = 16;
    localparam int STATUS_W = 2;

    localparam logic [CLK_W-1:0] FAST_CLK_RESET = 28'd90000000;
    localparam logic [CLK_W-1:0] SLOW_CLK_RESET = 28'd16000000;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_CLK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_CLK = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ZERO_BAUD = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

    // Divider: 25*clk over 2*baud or 4*baud
    localparam int NUM_W = CLK_W + 5;
    localparam int DEN_W = BAUD_W + 2;
    localparam int QUO_W = NUM_W;
    localparam int DIV_STEPS_PER_STAGE = 2;

    // Mantissa / fraction split
    localparam int MANT_W  = 12;
    localparam int X_W     = 19;
    localparam int REM_W   = 7;
    localparam int Y_W     = 11;
    localparam int FRAC_W  = 4;
    localparam logic [MANT_W-1:0] MANT_MAX = 12'd4095;
    localparam logic [QUO_W-1:0] SCALED_LIMIT = 33'd409600;   // (MANT_MAX + 1) * 100
    localparam logic [X_W-1:0] HUNDRED = 19'd100;
    localparam logic [Y_W-1:0] ROUND_HALF = 11'd50;
    // floor(v / 100) == (v * RECIP_100) >> RECIP_SHIFT for all v below 2^26 / 36
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;
    localparam int PROD_A_W = X_W + RECIP_W;
    localparam int PROD_C_W = Y_W + RECIP_W;

    typedef struct packed {
        logic [BAUD_W-1:0] baud_rate;
        logic              oversample_by_8;
        logic              on_fast_bus;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] divisor_word;
        status_t           status;
    } rsp_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             over8;
        logic             zero;
    } div_stage_t;

    // One restoring division step: brings in the next dividend bit
    function automatic div_stage_t div_step(div_stage_t d);
        div_stage_t     r;
        logic [DEN_W:0] trial;
        logic           ge;
        r     = d;
        trial = {d.rem, d.num[NUM_W-1]};
        ge    = (trial >= {1'b0, d.den});
        r.num = {d.num[NUM_W-2:0], 1'b0};
        r.quo = {d.quo[QUO_W-2:0], ge};
        r.rem = ge ? DEN_W'(trial - {1'b0, d.den}) : trial[DEN_W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/uart_baud_divisor_calc_core.sv =====
`timescale 1ns / 1ps
// Pipeline: with STEPS_PER_STAGE = 2, a request passes from acceptance to rsp_valid through
//   ceil(33 / STEPS_PER_STAGE) divider stages plus 5 further register stages.
// Throughput: one word per cycle; the restoring divider is fully pipelined,
//   and the whole pipe holds while a result waits at the output.
// Reset: rst_n clears all valid bits and loads the clock registers with
//   90 MHz (fast bus) and 16 MHz (slow bus).
module uart_baud_divisor_calc_core
    import ubdc_pkg::*;
#(
    parameter int STEPS_PER_STAGE = DIV_STEPS_PER_STAGE
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  req_t                   req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output rsp_t                   rsp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CLK_W-1:0]       cfg_data
);

    localparam int DIV_STAGES = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    typedef struct packed {
        logic [X_W-1:0]      x;
        logic [PROD_A_W-1:0] prod;
        logic                big;
        logic                over8;
        logic                zero;
    } post_a_t;

    typedef struct packed {
        logic [MANT_W-1:0] mant;
        logic [Y_W-1:0]    y;
        logic              big;
        logic              over8;
        logic              zero;
    } post_b_t;

    typedef struct packed {
        logic [MANT_W-1:0]   mant;
        logic [PROD_C_W-1:0] prod;
        logic                big;
        logic                over8;
        logic                zero;
    } post_c_t;

    logic [CLK_W-1:0] fast_clk_reg;
    logic [CLK_W-1:0] slow_clk_reg;

    logic             adv;

    div_stage_t div_reg [0:DIV_STAGES];
    logic       div_vld_reg [0:DIV_STAGES];
    div_stage_t div_next [0:DIV_STAGES];

    post_a_t post_a_reg, post_a_next;
    post_b_t post_b_reg, post_b_next;
    post_c_t post_c_reg, post_c_next;
    logic    post_a_vld_reg, post_b_vld_reg, post_c_vld_reg;

    rsp_t    rsp_reg, rsp_next;
    logic    rsp_valid_reg;

    // Whole pipe moves together unless the output word is held
    assign adv       = !rsp_valid_reg || rsp_ready;
    assign req_ready = adv;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_clk_reg <= FAST_CLK_RESET;
            slow_clk_reg <= SLOW_CLK_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FAST_CLK: fast_clk_reg <= cfg_data;
                REG_SLOW_CLK: slow_clk_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Entry: numerator 25*clk, denominator 4*baud (2*baud for x8)
    always_comb
    begin
        logic [NUM_W-1:0] clk_ext;
        clk_ext = NUM_W'(req.on_fast_bus ? fast_clk_reg : slow_clk_reg);
        div_next[0].num   = (clk_ext << 4) + (clk_ext << 3) + clk_ext;
        div_next[0].den   = req.oversample_by_8 ? {1'b0, req.baud_rate, 1'b0}
                                                : {req.baud_rate, 2'b00};
        div_next[0].rem   = '0;
        div_next[0].quo   = '0;
        div_next[0].over8 = req.oversample_by_8;
        div_next[0].zero  = (req.baud_rate == '0);
    end

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_div
            always_comb
            begin
                div_stage_t t;
                t = div_reg[s];
                for (int k = 0; k < STEPS_PER_STAGE; k++)
                begin
                    if (s * STEPS_PER_STAGE + k < QUO_W)
                    begin
                        t = div_step(t);
                    end
                end
                div_next[s+1] = t;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                div_vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            div_vld_reg[0] <= req_valid;
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                div_vld_reg[i] <= div_vld_reg[i-1];
            end
        end
    end

    // A: scaled / 100 by reciprocal; anything at or past the limit saturates
    always_comb
    begin
        div_stage_t d;
        d = div_reg[DIV_STAGES];
        post_a_next.big   = (d.quo >= SCALED_LIMIT);
        post_a_next.x     = d.quo[X_W-1:0];
        post_a_next.prod  = PROD_A_W'(d.quo[X_W-1:0]) * PROD_A_W'(RECIP_100);
        post_a_next.over8 = d.over8;
        post_a_next.zero  = d.zero;
    end

    // B: remainder and rounding numerator 16*R + 50 (8*R + 50 for x8)
    always_comb
    begin
        logic [MANT_W-1:0] mant;
        logic [X_W-1:0]    rem_full;
        logic [Y_W-1:0]    rem_ext;
        mant     = post_a_reg.prod[RECIP_SHIFT +: MANT_W];
        rem_full = post_a_reg.x - X_W'(mant) * HUNDRED;
        rem_ext  = Y_W'(rem_full[REM_W-1:0]);
        post_b_next.mant  = mant;
        post_b_next.y     = (post_a_reg.over8 ? (rem_ext << 3) : (rem_ext << 4)) + ROUND_HALF;
        post_b_next.big   = post_a_reg.big;
        post_b_next.over8 = post_a_reg.over8;
        post_b_next.zero  = post_a_reg.zero;
    end

    // C: rounding numerator / 100
    always_comb
    begin
        post_c_next.mant  = post_b_reg.mant;
        post_c_next.prod  = PROD_C_W'(post_b_reg.y) * PROD_C_W'(RECIP_100);
        post_c_next.big   = post_b_reg.big;
        post_c_next.over8 = post_b_reg.over8;
        post_c_next.zero  = post_b_reg.zero;
    end

    // D: fraction carry into mantissa, saturation, packing
    always_comb
    begin
        logic [FRAC_W:0]   frac_raw;
        logic [FRAC_W:0]   full;
        logic              carry;
        logic [FRAC_W-1:0] frac;
        logic [MANT_W:0]   mant_rnd;
        frac_raw = post_c_reg.prod[RECIP_SHIFT +: FRAC_W+1];
        full     = post_c_reg.over8 ? 5'd8 : 5'd16;
        carry    = (frac_raw >= full);
        frac     = carry ? '0 : frac_raw[FRAC_W-1:0];
        mant_rnd = {1'b0, post_c_reg.mant} + (MANT_W+1)'(carry);
        if (post_c_reg.zero)
        begin
            rsp_next.divisor_word = '0;
            rsp_next.status       = STATUS_ZERO_BAUD;
        end
        else if (post_c_reg.big || mant_rnd[MANT_W])
        begin
            rsp_next.divisor_word = {MANT_MAX, post_c_reg.over8 ? 4'h7 : 4'hF};
            rsp_next.status       = STATUS_SATURATED;
        end
        else
        begin
            rsp_next.divisor_word = {mant_rnd[MANT_W-1:0], frac};
            rsp_next.status       = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            post_a_reg <= post_a_next;
            post_b_reg <= post_b_next;
            post_c_reg <= post_c_next;
            rsp_reg    <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_a_vld_reg <= 1'b0;
            post_b_vld_reg <= 1'b0;
            post_c_vld_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            post_a_vld_reg <= div_vld_reg[DIV_STAGES];
            post_b_vld_reg <= post_a_vld_reg;
            post_c_vld_reg <= post_b_vld_reg;
            rsp_valid_reg  <= post_c_vld_reg;
        end
    end

endmodule
